>>> sv/adc_seq_pkg.sv
package adc_seq_pkg;

    // converter sample width; the frequency map divides by 2**SAMPLE_BITS - 1
    localparam int SAMPLE_BITS = 12;
    localparam int FREQ_W      = 16;
    localparam int TICK_W      = 8;
    localparam int OP_W        = 3;
    localparam int PHASE_W     = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam int RAW_MAX  = (1 << SAMPLE_BITS) - 1;
    localparam int PROD_W   = SAMPLE_BITS + FREQ_W;
    localparam int SUM_W    = FREQ_W + 1;
    localparam int HI_W     = SUM_W - SAMPLE_BITS;
    localparam int Z_W      = SAMPLE_BITS + 2;

    localparam logic [FREQ_W-1:0] MIN_FREQ_RST = FREQ_W'(125);
    localparam logic [FREQ_W-1:0] MAX_FREQ_RST = FREQ_W'(5000);
    localparam logic [TICK_W-1:0] INTERVAL_RST = TICK_W'(20);
    localparam logic [TICK_W-1:0] STARTUP_RST  = TICK_W'(1);

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FREQ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FREQ = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP  = 2'd3;

    typedef enum logic [OP_W-1:0] {
        OP_START   = 3'd0,
        OP_TICK    = 3'd1,
        OP_DONE    = 3'd2,
        OP_OVERRUN = 3'd3,
        OP_TAKE    = 3'd4,
        OP_LATEST  = 3'd5
    } t_op;

    typedef enum logic [PHASE_W-1:0] {
        PH_OFF      = 3'd0,
        PH_STARTUP  = 3'd1,
        PH_CAL      = 3'd2,
        PH_ENABLING = 3'd3,
        PH_READY    = 3'd4
    } t_phase;

    // one word leaving the sequencer, before the frequency is attached
    typedef struct packed {
        t_phase                 phase;
        logic                   reg_en;
        logic                   cal_start;
        logic                   conv_en;
        logic                   conv_start;
        logic [SAMPLE_BITS-1:0] raw;
        logic                   delivered;
        logic                   ready;
        logic                   is_start;
        logic                   is_done;
    } t_seq_word;

endpackage

>>> sv/adc_seq_if.sv
interface adc_seq_in_if import adc_seq_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [OP_W-1:0]        opcode;
    logic [SAMPLE_BITS-1:0] raw_sample;
    logic                   calibration_busy;
    logic                   converter_ready_flag;
    logic                   converter_enabled;
    logic                   conversion_ongoing;

    modport source (
        output valid, opcode, raw_sample, calibration_busy, converter_ready_flag,
               converter_enabled, conversion_ongoing,
        input  ready
    );
    modport sink (
        input  valid, opcode, raw_sample, calibration_busy, converter_ready_flag,
               converter_enabled, conversion_ongoing,
        output ready
    );
endinterface

interface adc_seq_out_if import adc_seq_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [PHASE_W-1:0]     phase;
    logic                   regulator_enable;
    logic                   calibration_start;
    logic                   converter_enable;
    logic                   conversion_start;
    logic [SAMPLE_BITS-1:0] sample_raw;
    logic [FREQ_W-1:0]      mapped_freq;
    logic                   sample_delivered;
    logic                   sample_ready;

    modport source (
        output valid, phase, regulator_enable, calibration_start, converter_enable,
               conversion_start, sample_raw, mapped_freq, sample_delivered,
               sample_ready,
        input  ready
    );
    modport sink (
        input  valid, phase, regulator_enable, calibration_start, converter_enable,
               conversion_start, sample_raw, mapped_freq, sample_delivered,
               sample_ready,
        output ready
    );
endinterface

interface adc_seq_cfg_if import adc_seq_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> sv/adc_seq_ctrl.sv
module adc_seq_ctrl import adc_seq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    adc_seq_in_if.sink        i_item,
    input  logic [TICK_W-1:0] i_interval_ticks,
    input  logic [TICK_W-1:0] i_startup_ticks,
    output logic              o_valid,
    output t_seq_word         o_word,
    input  logic              i_ready
);

    t_phase                 r_phase, n_phase;
    logic [TICK_W-1:0]      r_startup_cnt, n_startup_cnt;
    logic [TICK_W-1:0]      r_interval_cnt, n_interval_cnt;
    logic                   r_conv_active, n_conv_active;
    logic                   r_update_pending, n_update_pending;
    logic                   r_sample_valid, n_sample_valid;
    logic [SAMPLE_BITS-1:0] r_stored_raw, n_stored_raw;

    logic                   r_valid;
    t_seq_word              r_word;
    t_seq_word              n_word;
    logic                   accept;
    logic                   trigger_ok;

    assign i_item.ready = !r_valid || i_ready;
    assign accept       = i_item.valid && i_item.ready;
    assign trigger_ok   = !r_conv_active && i_item.converter_enabled
                          && !i_item.conversion_ongoing;

    // next state
    always_comb begin
        n_phase          = r_phase;
        n_startup_cnt    = r_startup_cnt;
        n_interval_cnt   = r_interval_cnt;
        n_conv_active    = r_conv_active;
        n_update_pending = r_update_pending;
        n_sample_valid   = r_sample_valid;
        n_stored_raw     = r_stored_raw;
        unique case (t_op'(i_item.opcode))
            OP_START: begin
                n_stored_raw     = '0;
                n_update_pending = 1'b0;
                n_sample_valid   = 1'b0;
                n_conv_active    = 1'b0;
                n_interval_cnt   = i_interval_ticks;
                n_startup_cnt    = i_startup_ticks;
                n_phase          = PH_STARTUP;
            end
            OP_TICK: begin
                unique case (r_phase)
                    PH_STARTUP: begin
                        if (r_startup_cnt != '0) begin
                            n_startup_cnt = r_startup_cnt - 1'b1;
                        end else begin
                            n_phase = PH_CAL;
                        end
                    end
                    PH_CAL: begin
                        if (!i_item.calibration_busy) begin
                            n_phase = PH_ENABLING;
                        end
                    end
                    PH_ENABLING: begin
                        if (i_item.converter_ready_flag) begin
                            n_phase        = PH_READY;
                            n_interval_cnt = '0;
                        end
                    end
                    PH_READY: begin
                        if (r_interval_cnt != '0) begin
                            n_interval_cnt = r_interval_cnt - 1'b1;
                        end else begin
                            n_interval_cnt = i_interval_ticks;
                            if (trigger_ok) begin
                                n_conv_active = 1'b1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            OP_DONE: begin
                n_stored_raw     = i_item.raw_sample;
                n_sample_valid   = 1'b1;
                n_update_pending = 1'b1;
                n_conv_active    = 1'b0;
            end
            OP_OVERRUN: begin
                n_conv_active = 1'b0;
            end
            OP_TAKE: begin
                n_update_pending = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // result word
    always_comb begin
        n_word          = '0;
        n_word.phase    = n_phase;
        n_word.raw      = n_stored_raw;
        unique case (t_op'(i_item.opcode))
            OP_START: begin
                n_word.reg_en   = 1'b1;
                n_word.is_start = 1'b1;
            end
            OP_TICK: begin
                n_word.cal_start  = (r_phase == PH_STARTUP) && (r_startup_cnt == '0);
                n_word.conv_en    = (r_phase == PH_CAL) && !i_item.calibration_busy;
                n_word.conv_start = (r_phase == PH_READY) && (r_interval_cnt == '0)
                                    && trigger_ok;
            end
            OP_DONE: begin
                n_word.is_done = 1'b1;
            end
            OP_TAKE: begin
                n_word.delivered = r_update_pending;
                n_word.ready     = r_update_pending && (r_phase == PH_READY)
                                   && r_sample_valid;
            end
            OP_LATEST: begin
                n_word.delivered = 1'b1;
                n_word.ready     = (r_phase == PH_READY) && r_sample_valid;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_OFF;
            r_startup_cnt    <= '0;
            r_interval_cnt   <= INTERVAL_RST;
            r_conv_active    <= 1'b0;
            r_update_pending <= 1'b0;
            r_sample_valid   <= 1'b0;
            r_stored_raw     <= '0;
            r_valid          <= 1'b0;
        end else begin
            if (accept) begin
                r_phase          <= n_phase;
                r_startup_cnt    <= n_startup_cnt;
                r_interval_cnt   <= n_interval_cnt;
                r_conv_active    <= n_conv_active;
                r_update_pending <= n_update_pending;
                r_sample_valid   <= n_sample_valid;
                r_stored_raw     <= n_stored_raw;
                r_valid          <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

    a_start_enters_startup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_item.opcode == OP_START)
        |=> r_valid && (r_word.phase == PH_STARTUP) && !r_sample_valid)
        else $error("start did not restart the sequence");

    a_conv_start_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_word.conv_start |-> (r_word.phase == PH_READY) && r_conv_active)
        else $error("conversion start outside ready phase or without active flag");

    a_done_marks_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_item.opcode == OP_DONE)
        |=> r_update_pending && r_sample_valid && !r_conv_active)
        else $error("conversion done did not mark a pending sample");

endmodule

>>> sv/adc_seq_map.sv
module adc_seq_map import adc_seq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_seq_word         i_word,
    output logic              o_ready,
    input  logic [FREQ_W-1:0] i_min_freq,
    input  logic [FREQ_W-1:0] i_max_freq,
    adc_seq_out_if.source     o_result
);

    // stage 2: product, stage 3: quotient, stage 4: result register
    logic                   r_v2, r_v3, r_v4;
    t_seq_word              r_w2, r_w3, r_w4;
    logic [PROD_W-1:0]      r_prod2;
    logic [FREQ_W-1:0]      r_q3;
    logic [FREQ_W-1:0]      r_freq;

    logic                   rdy2, rdy3, rdy4;
    logic [FREQ_W-1:0]      span;
    logic [FREQ_W-1:0]      prod_hi;
    logic [SAMPLE_BITS-1:0] prod_lo;
    logic [SUM_W-1:0]       fold1;
    logic [HI_W-1:0]        fold_hi;
    logic [Z_W-1:0]         fold2;
    logic [SUM_W-1:0]       quot;
    logic [SUM_W-1:0]       freq_sum;
    logic [FREQ_W-1:0]      freq_new;

    assign rdy4    = !r_v4 || o_result.ready;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign o_ready = rdy2;

    assign span = (i_max_freq >= i_min_freq) ? (i_max_freq - i_min_freq) : '0;

    // x / (2^S - 1): fold the high part back onto the low part twice,
    // then at most two corrections
    assign prod_hi = r_prod2[PROD_W-1:SAMPLE_BITS];
    assign prod_lo = r_prod2[SAMPLE_BITS-1:0];
    assign fold1   = SUM_W'(prod_hi) + SUM_W'(prod_lo);
    assign fold_hi = fold1[SUM_W-1:SAMPLE_BITS];
    assign fold2   = Z_W'(fold_hi) + Z_W'(fold1[SAMPLE_BITS-1:0]);
    assign quot    = SUM_W'(prod_hi) + SUM_W'(fold_hi)
                     + SUM_W'(fold2 >= Z_W'(RAW_MAX))
                     + SUM_W'(fold2 >= Z_W'(2 * RAW_MAX));

    assign freq_sum = SUM_W'(i_min_freq) + SUM_W'(r_q3);
    assign freq_new = (freq_sum > SUM_W'(i_max_freq)) ? i_max_freq
                                                      : freq_sum[FREQ_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_freq <= MIN_FREQ_RST;
        end else begin
            if (rdy2) begin
                r_v2 <= i_valid;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
                if (r_v3 && r_w3.is_start) begin
                    r_freq <= i_min_freq;
                end else if (r_v3 && r_w3.is_done) begin
                    r_freq <= freq_new;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_w2    <= i_word;
            r_prod2 <= PROD_W'(i_word.raw) * PROD_W'(span);
        end
        if (rdy3) begin
            r_w3 <= r_w2;
            r_q3 <= quot[FREQ_W-1:0];
        end
        if (rdy4) begin
            r_w4 <= r_w3;
        end
    end

    assign o_result.valid             = r_v4;
    assign o_result.phase             = r_w4.phase;
    assign o_result.regulator_enable  = r_w4.reg_en;
    assign o_result.calibration_start = r_w4.cal_start;
    assign o_result.converter_enable  = r_w4.conv_en;
    assign o_result.conversion_start  = r_w4.conv_start;
    assign o_result.sample_raw        = r_w4.raw;
    assign o_result.mapped_freq       = r_freq;
    assign o_result.sample_delivered  = r_w4.delivered;
    assign o_result.sample_ready      = r_w4.ready;

    a_quotient_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && rdy3
        |=> (64'(r_q3) * 64'(RAW_MAX) <= 64'($past(r_prod2)))
            && (64'($past(r_prod2)) < (64'(r_q3) + 64'd1) * 64'(RAW_MAX)))
        else $error("constant divide result off");

    a_start_loads_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && rdy4 && r_w3.is_start |=> r_freq == $past(i_min_freq))
        else $error("start did not load minimum frequency");

    a_done_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && rdy4 && r_w3.is_done |=> r_freq <= $past(i_max_freq))
        else $error("mapped frequency above maximum");

endmodule

>>> sv/adc_bringup_and_sample_sequencer.sv
// channel   modport  words
// i_item    sink     event: opcode, raw sample, converter status flags
// o_result  source   phase, pulses, stored sample, frequency, query answer
// i_cfg     sink     register write: index 0 min, 1 max, 2 interval, 3 startup
//
// One event per cycle while i_item.ready is high; results leave in order.
// The sequencer step is done at the input edge; the frequency map runs through a
// multiply stage, a constant-divide stage and an add/clamp stage into the result
// register. Synchronous active-low reset restores the off phase and register
// defaults. A stalled result fills bubbles before i_item.ready drops.
module adc_bringup_and_sample_sequencer import adc_seq_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    adc_seq_in_if.sink    i_item,
    adc_seq_out_if.source o_result,
    adc_seq_cfg_if.sink   i_cfg
);

    logic [FREQ_W-1:0] r_min_freq;
    logic [FREQ_W-1:0] r_max_freq;
    logic [TICK_W-1:0] r_interval;
    logic [TICK_W-1:0] r_startup;

    logic              seq_valid;
    logic              seq_ready;
    t_seq_word         seq_word;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_freq <= MIN_FREQ_RST;
            r_max_freq <= MAX_FREQ_RST;
            r_interval <= INTERVAL_RST;
            r_startup  <= STARTUP_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_MIN_FREQ: r_min_freq <= i_cfg.data;
                CFG_MAX_FREQ: r_max_freq <= i_cfg.data;
                CFG_INTERVAL: r_interval <= i_cfg.data[TICK_W-1:0];
                CFG_STARTUP:  r_startup  <= i_cfg.data[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    adc_seq_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item           (i_item),
        .i_interval_ticks (r_interval),
        .i_startup_ticks  (r_startup),
        .o_valid          (seq_valid),
        .o_word           (seq_word),
        .i_ready          (seq_ready)
    );

    adc_seq_map u_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (seq_valid),
        .i_word     (seq_word),
        .o_ready    (seq_ready),
        .i_min_freq (r_min_freq),
        .i_max_freq (r_max_freq),
        .o_result   (o_result)
    );

endmodule
